// File: hdl/idm_pkg.sv
`default_nettype none
package idm_pkg;

    localparam int CH_W       = 16;
    localparam int CNT_W      = 23;
    localparam int RGB_ABS_W  = 42;
    localparam int RGB_SQ_W   = 56;
    localparam int LUM_ABS_W  = 38;
    localparam int LUM_SQ_W   = 54;
    localparam int LUM_SUM_W  = 38;
    localparam int DVD_W      = 56;
    localparam int DVS_W      = 24;
    localparam int MSQ_W      = 32;

    localparam logic [CNT_W-1:0] MAX_PIXELS    = 23'd4194304;
    localparam logic [CH_W-1:0]  THRESH_RESET  = 16'd41;
    localparam logic [CH_W-1:0]  W_RED         = 16'd13933;
    localparam logic [CH_W-1:0]  W_GREEN       = 16'd46871;
    localparam logic [CH_W-1:0]  W_BLUE        = 16'd4732;

    // Accumulator image handed from the front to the back at the last pixel
    typedef struct packed {
        logic [RGB_ABS_W-1:0] rgb_abs;
        logic [RGB_SQ_W-1:0]  rgb_sq;
        logic [LUM_ABS_W-1:0] lum_abs;
        logic [LUM_SQ_W-1:0]  lum_sq;
        logic [LUM_SUM_W-1:0] base_lum;
        logic [LUM_SUM_W-1:0] cand_lum;
        logic [CH_W-1:0]      max_err;
        logic [CNT_W-1:0]     above;
        logic [CNT_W-1:0]     count;
    } t_snap;

endpackage
`default_nettype wire

// File: hdl/idm_front.sv
`default_nettype none
module idm_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_accept,
    input  wire logic [15:0]          i_thresh,
    input  wire logic [15:0]          i_base_red,
    input  wire logic [15:0]          i_base_green,
    input  wire logic [15:0]          i_base_blue,
    input  wire logic [15:0]          i_cand_red,
    input  wire logic [15:0]          i_cand_green,
    input  wire logic [15:0]          i_cand_blue,
    input  wire logic                 i_last_pixel,
    output logic                      o_tail_last,
    output logic                      o_push,
    output idm_pkg::t_snap            o_snap
);
    import idm_pkg::*;

    logic [CH_W-1:0] d_r, d_g, d_b, pmax_rg, pmax;

    logic            r_s1_v, r_s1_last, r_s1_exc;
    logic [CH_W-1:0] r_s1_dr, r_s1_dg, r_s1_db, r_s1_max;
    logic [CH_W-1:0] r_s1_br, r_s1_bg, r_s1_bb, r_s1_cr, r_s1_cg, r_s1_cb;

    logic            r_s2_v, r_s2_last, r_s2_exc;
    logic [31:0]     r_s2_sr, r_s2_sg, r_s2_sb;
    logic [17:0]     r_s2_abs3;
    logic [CH_W-1:0] r_s2_lb, r_s2_lc, r_s2_max;

    logic            r_s3_v, r_s3_last, r_s3_exc;
    logic [33:0]     r_s3_sq3;
    logic [17:0]     r_s3_abs3;
    logic [CH_W-1:0] r_s3_lb, r_s3_lc, r_s3_ld, r_s3_max;

    logic            r_s4_v, r_s4_last, r_s4_exc;
    logic [33:0]     r_s4_sq3;
    logic [31:0]     r_s4_ldsq;
    logic [17:0]     r_s4_abs3;
    logic [CH_W-1:0] r_s4_lb, r_s4_lc, r_s4_ld, r_s4_max;

    logic [31:0] lb_full, lc_full;

    t_snap r_acc, n_acc;
    logic  acc_take;

    assign d_r     = (i_cand_red   > i_base_red)   ? i_cand_red   - i_base_red
                                                   : i_base_red   - i_cand_red;
    assign d_g     = (i_cand_green > i_base_green) ? i_cand_green - i_base_green
                                                   : i_base_green - i_cand_green;
    assign d_b     = (i_cand_blue  > i_base_blue)  ? i_cand_blue  - i_base_blue
                                                   : i_base_blue  - i_cand_blue;
    assign pmax_rg = (d_g > d_r) ? d_g : d_r;
    assign pmax    = (d_b > pmax_rg) ? d_b : pmax_rg;

    assign lb_full = W_RED * r_s1_br + W_GREEN * r_s1_bg + W_BLUE * r_s1_bb;
    assign lc_full = W_RED * r_s1_cr + W_GREEN * r_s1_cg + W_BLUE * r_s1_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_last <= i_last_pixel;
            r_s1_exc  <= pmax > i_thresh;
            r_s1_dr   <= d_r;
            r_s1_dg   <= d_g;
            r_s1_db   <= d_b;
            r_s1_max  <= pmax;
            r_s1_br   <= i_base_red;
            r_s1_bg   <= i_base_green;
            r_s1_bb   <= i_base_blue;
            r_s1_cr   <= i_cand_red;
            r_s1_cg   <= i_cand_green;
            r_s1_cb   <= i_cand_blue;

            r_s2_last <= r_s1_last;
            r_s2_exc  <= r_s1_exc;
            r_s2_max  <= r_s1_max;
            r_s2_sr   <= r_s1_dr * r_s1_dr;
            r_s2_sg   <= r_s1_dg * r_s1_dg;
            r_s2_sb   <= r_s1_db * r_s1_db;
            r_s2_abs3 <= 18'(r_s1_dr) + 18'(r_s1_dg) + 18'(r_s1_db);
            r_s2_lb   <= lb_full[31:16];
            r_s2_lc   <= lc_full[31:16];

            r_s3_last <= r_s2_last;
            r_s3_exc  <= r_s2_exc;
            r_s3_max  <= r_s2_max;
            r_s3_sq3  <= 34'(r_s2_sr) + 34'(r_s2_sg) + 34'(r_s2_sb);
            r_s3_abs3 <= r_s2_abs3;
            r_s3_lb   <= r_s2_lb;
            r_s3_lc   <= r_s2_lc;
            r_s3_ld   <= (r_s2_lc > r_s2_lb) ? r_s2_lc - r_s2_lb : r_s2_lb - r_s2_lc;

            r_s4_last <= r_s3_last;
            r_s4_exc  <= r_s3_exc;
            r_s4_max  <= r_s3_max;
            r_s4_sq3  <= r_s3_sq3;
            r_s4_abs3 <= r_s3_abs3;
            r_s4_lb   <= r_s3_lb;
            r_s4_lc   <= r_s3_lc;
            r_s4_ld   <= r_s3_ld;
            r_s4_ldsq <= r_s3_ld * r_s3_ld;
        end
    end

    assign acc_take = i_en && r_s4_v;

    // Drop pixels once the counter is full; the result still goes out on last
    always_comb begin
        n_acc = r_acc;
        if (r_acc.count < MAX_PIXELS) begin
            n_acc.rgb_abs  = r_acc.rgb_abs  + RGB_ABS_W'(r_s4_abs3);
            n_acc.rgb_sq   = r_acc.rgb_sq   + RGB_SQ_W'(r_s4_sq3);
            n_acc.lum_abs  = r_acc.lum_abs  + LUM_ABS_W'(r_s4_ld);
            n_acc.lum_sq   = r_acc.lum_sq   + LUM_SQ_W'(r_s4_ldsq);
            n_acc.base_lum = r_acc.base_lum + LUM_SUM_W'(r_s4_lb);
            n_acc.cand_lum = r_acc.cand_lum + LUM_SUM_W'(r_s4_lc);
            n_acc.max_err  = (r_s4_max > r_acc.max_err) ? r_s4_max : r_acc.max_err;
            n_acc.above    = r_acc.above + CNT_W'(r_s4_exc);
            n_acc.count    = r_acc.count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (acc_take) begin
            r_acc <= r_s4_last ? '0 : n_acc;
        end
    end

    assign o_tail_last = r_s4_v && r_s4_last;
    assign o_push      = acc_take && r_s4_last;
    assign o_snap      = n_acc;

endmodule
`default_nettype wire

// File: hdl/idm_queue.sv
`default_nettype none
module idm_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  idm_pkg::t_snap            i_data,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output logic                      o_nonempty,
    output idm_pkg::t_snap            o_data
);
    import idm_pkg::*;

    t_snap       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full     = r_cnt == 2'd2;
    assign o_nonempty = r_cnt != 2'd0;
    assign o_data     = r_mem[r_rp];

endmodule
`default_nettype wire

// File: hdl/idm_back.sv
`default_nettype none
module idm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_avail,
    input  idm_pkg::t_snap            i_snap,
    output logic                      o_pop,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [15:0]               o_rgb_mean_abs_error,
    output logic [15:0]               o_rgb_rms_error,
    output logic [15:0]               o_lum_mean_abs_error,
    output logic [15:0]               o_lum_rms_error,
    output logic [15:0]               o_max_channel_error,
    output logic [15:0]               o_mean_base_lum,
    output logic [15:0]               o_mean_cand_lum,
    output logic [22:0]               o_above_count,
    output logic [22:0]               o_total_pixels
);
    import idm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DLOAD = 6'b000010,
        S_DIV   = 6'b000100,
        S_SLOAD = 6'b001000,
        S_SQRT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    localparam logic [2:0] JOB_RGB_ABS = 3'd0;
    localparam logic [2:0] JOB_RGB_SQ  = 3'd1;
    localparam logic [2:0] JOB_LUM_ABS = 3'd2;
    localparam logic [2:0] JOB_LUM_SQ  = 3'd3;
    localparam logic [2:0] JOB_BASE    = 3'd4;
    localparam logic [2:0] JOB_CAND    = 3'd5;

    t_state          r_state;
    t_snap           r_snap;
    logic [2:0]      r_job;
    logic [5:0]      r_cnt;
    logic [DVD_W-1:0] r_dvd, r_quo, n_quo, dvd_sel;
    logic [DVS_W:0]  r_rem, rem_sh;
    logic [DVS_W-1:0] n_one, dvs;
    logic            ge;
    logic            r_sjob;
    logic [MSQ_W-1:0] r_rad, r_msq_rgb, r_msq_lum;
    logic [15:0]     r_root, n_root;
    logic [17:0]     r_srem;
    logic [18:0]     srem_sh, trial;
    logic            sge;
    logic [15:0]     r_mae_rgb, r_mae_lum, r_rms_rgb, r_rms_lum, r_mbase, r_mcand;

    assign n_one = (r_snap.count == '0) ? DVS_W'(1) : DVS_W'(r_snap.count);
    assign dvs   = (r_job == JOB_RGB_ABS || r_job == JOB_RGB_SQ)
                   ? n_one + (n_one << 1) : n_one;

    always_comb begin
        case (r_job)
            JOB_RGB_ABS: dvd_sel = DVD_W'(r_snap.rgb_abs);
            JOB_RGB_SQ:  dvd_sel = DVD_W'(r_snap.rgb_sq);
            JOB_LUM_ABS: dvd_sel = DVD_W'(r_snap.lum_abs);
            JOB_LUM_SQ:  dvd_sel = DVD_W'(r_snap.lum_sq);
            JOB_BASE:    dvd_sel = DVD_W'(r_snap.base_lum);
            JOB_CAND:    dvd_sel = DVD_W'(r_snap.cand_lum);
            default:     dvd_sel = '0;
        endcase
    end

    // Restoring division, one quotient bit a cycle
    assign rem_sh = {r_rem[DVS_W-1:0], r_dvd[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs};
    assign n_quo  = {r_quo[DVD_W-2:0], ge};

    // Digit-by-digit square root, one result bit a cycle
    assign srem_sh = {r_srem[16:0], r_rad[MSQ_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign sge     = srem_sh >= trial;
    assign n_root  = {r_root[14:0], sge};

    assign o_pop = (r_state == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_RGB_ABS;
            r_sjob  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_state <= S_DLOAD;
                        r_job   <= JOB_RGB_ABS;
                    end
                end
                S_DLOAD: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DVD_W - 1)) begin
                        if (r_job == JOB_CAND) begin
                            r_state <= S_SLOAD;
                            r_sjob  <= 1'b0;
                        end else begin
                            r_state <= S_DLOAD;
                            r_job   <= r_job + 3'd1;
                        end
                    end
                end
                S_SLOAD: begin
                    r_state <= S_SQRT;
                    r_cnt   <= '0;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        if (r_sjob) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SLOAD;
                            r_sjob  <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_snap <= i_snap;
        case (r_state)
            S_DLOAD: begin
                r_dvd <= dvd_sel;
                r_rem <= '0;
                r_quo <= '0;
            end
            S_DIV: begin
                r_dvd <= r_dvd << 1;
                r_rem <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
                r_quo <= n_quo;
                if (r_cnt == 6'(DVD_W - 1)) begin
                    case (r_job)
                        JOB_RGB_ABS: r_mae_rgb <= n_quo[15:0];
                        JOB_RGB_SQ:  r_msq_rgb <= n_quo[MSQ_W-1:0];
                        JOB_LUM_ABS: r_mae_lum <= n_quo[15:0];
                        JOB_LUM_SQ:  r_msq_lum <= n_quo[MSQ_W-1:0];
                        JOB_BASE:    r_mbase   <= n_quo[15:0];
                        default:     r_mcand   <= n_quo[15:0];
                    endcase
                end
            end
            S_SLOAD: begin
                r_rad  <= r_sjob ? r_msq_lum : r_msq_rgb;
                r_srem <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_rad  <= r_rad << 2;
                r_srem <= sge ? 18'(srem_sh - trial) : srem_sh[17:0];
                r_root <= n_root;
                if (r_cnt == 6'd15) begin
                    if (r_sjob) r_rms_lum <= n_root;
                    else        r_rms_rgb <= n_root;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid          = r_state == S_OUT;
    assign o_rgb_mean_abs_error = r_mae_rgb;
    assign o_rgb_rms_error      = r_rms_rgb;
    assign o_lum_mean_abs_error = r_mae_lum;
    assign o_lum_rms_error      = r_rms_lum;
    assign o_max_channel_error  = r_snap.max_err;
    assign o_mean_base_lum      = r_mbase;
    assign o_mean_cand_lum      = r_mcand;
    assign o_above_count        = r_snap.above;
    assign o_total_pixels       = r_snap.count;

endmodule
`default_nettype wire

// File: hdl/image_difference_metrics.sv
// Pixel pairs are taken one per cycle while o_in_stall is low; each pixel passes the registered
// stages s1 to s4 before the accumulators. After the last pixel the back end runs six 56-step
// divisions and two 16-step roots on separate divider and square-root datapaths.
// A two-entry queue holds finished images; input stalls only if a last pixel finds it full.
// Synchronous active-low reset clears accumulators, queue and sequencer; threshold resets to 41.
`default_nettype none
module image_difference_metrics (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_base_red,
    input  wire logic [15:0] i_base_green,
    input  wire logic [15:0] i_base_blue,
    input  wire logic [15:0] i_cand_red,
    input  wire logic [15:0] i_cand_green,
    input  wire logic [15:0] i_cand_blue,
    input  wire logic        i_last_pixel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_rgb_mean_abs_error,
    output logic [15:0]      o_rgb_rms_error,
    output logic [15:0]      o_lum_mean_abs_error,
    output logic [15:0]      o_lum_rms_error,
    output logic [15:0]      o_max_channel_error,
    output logic [15:0]      o_mean_base_lum,
    output logic [15:0]      o_mean_cand_lum,
    output logic [22:0]      o_above_count,
    output logic [22:0]      o_total_pixels
);
    import idm_pkg::*;

    logic [CH_W-1:0] r_thresh;
    logic            en, tail_last, q_push, q_pop, q_full, q_nonempty;
    t_snap           snap_in, snap_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Hold the pipeline while a last pixel waits for queue space
    assign en         = !(tail_last && q_full);
    assign o_in_stall = !en;

    idm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_accept     (i_in_valid && en),
        .i_thresh     (r_thresh),
        .i_base_red   (i_base_red),
        .i_base_green (i_base_green),
        .i_base_blue  (i_base_blue),
        .i_cand_red   (i_cand_red),
        .i_cand_green (i_cand_green),
        .i_cand_blue  (i_cand_blue),
        .i_last_pixel (i_last_pixel),
        .o_tail_last  (tail_last),
        .o_push       (q_push),
        .o_snap       (snap_in)
    );

    idm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_data     (snap_in),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_data     (snap_out)
    );

    idm_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_avail              (q_nonempty),
        .i_snap               (snap_out),
        .o_pop                (q_pop),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_rgb_mean_abs_error (o_rgb_mean_abs_error),
        .o_rgb_rms_error      (o_rgb_rms_error),
        .o_lum_mean_abs_error (o_lum_mean_abs_error),
        .o_lum_rms_error      (o_lum_rms_error),
        .o_max_channel_error  (o_max_channel_error),
        .o_mean_base_lum      (o_mean_base_lum),
        .o_mean_cand_lum      (o_mean_cand_lum),
        .o_above_count        (o_above_count),
        .o_total_pixels       (o_total_pixels)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_above_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_above_count <= o_total_pixels))
        else $error("above count exceeds pixel count");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
    import idm_pkg::*;

    typedef struct {
        logic [15:0] rgb_mae;
        logic [15:0] rgb_rms;
        logic [15:0] lum_mae;
        logic [15:0] lum_rms;
        logic [15:0] max_err;
        logic [15:0] base_lum;
        logic [15:0] cand_lum;
        logic [22:0] above;
        logic [22:0] total;
    } t_metrics;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_base_red, i_base_green, i_base_blue;
    logic [15:0] i_cand_red, i_cand_green, i_cand_blue;
    logic        i_last_pixel;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_rgb_mean_abs_error, o_rgb_rms_error, o_lum_mean_abs_error;
    logic [15:0] o_lum_rms_error, o_max_channel_error, o_mean_base_lum, o_mean_cand_lum;
    logic [22:0] o_above_count, o_total_pixels;

    image_difference_metrics i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_base_red(i_base_red), .i_base_green(i_base_green), .i_base_blue(i_base_blue),
        .i_cand_red(i_cand_red), .i_cand_green(i_cand_green), .i_cand_blue(i_cand_blue),
        .i_last_pixel(i_last_pixel),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_rgb_mean_abs_error(o_rgb_mean_abs_error), .o_rgb_rms_error(o_rgb_rms_error),
        .o_lum_mean_abs_error(o_lum_mean_abs_error), .o_lum_rms_error(o_lum_rms_error),
        .o_max_channel_error(o_max_channel_error), .o_mean_base_lum(o_mean_base_lum),
        .o_mean_cand_lum(o_mean_cand_lum), .o_above_count(o_above_count),
        .o_total_pixels(o_total_pixels)
    );

    // Model state
    logic [15:0]       threshold;
    longint unsigned   acc_rgb_abs, acc_rgb_sq, acc_lum_abs, acc_lum_sq;
    longint unsigned   acc_base_lum, acc_cand_lum, acc_max_err, acc_above, acc_count;
    t_metrics          pending_metrics[$];
    int                mismatches;
    bit                fail_seen;
    bit                quiet;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned luminance(longint unsigned r, longint unsigned g,
                                                  longint unsigned b);
        return (64'd13933 * r + 64'd46871 * g + 64'd4732 * b) >> 16;
    endfunction

    function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    task automatic clear_sums();
        acc_rgb_abs = 0; acc_rgb_sq = 0; acc_lum_abs = 0; acc_lum_sq = 0;
        acc_base_lum = 0; acc_cand_lum = 0; acc_max_err = 0; acc_above = 0; acc_count = 0;
    endtask

    task automatic accumulate_pixel();
        longint unsigned bch[3], cch[3];
        longint unsigned d, pmax, lb, lc, ld, n;
        t_metrics m;
        bch[0] = i_base_red; bch[1] = i_base_green; bch[2] = i_base_blue;
        cch[0] = i_cand_red; cch[1] = i_cand_green; cch[2] = i_cand_blue;
        if (acc_count < 64'd4194304) begin
            pmax = 0;
            for (int c = 0; c < 3; c++) begin
                d = absdiff(cch[c], bch[c]);
                acc_rgb_abs += d;
                acc_rgb_sq += d * d;
                if (d > pmax) pmax = d;
            end
            if (pmax > acc_max_err) acc_max_err = pmax;
            if (pmax > threshold) acc_above++;
            lb = luminance(bch[0], bch[1], bch[2]);
            lc = luminance(cch[0], cch[1], cch[2]);
            ld = absdiff(lc, lb);
            acc_lum_abs += ld;
            acc_lum_sq += ld * ld;
            acc_base_lum += lb;
            acc_cand_lum += lc;
            acc_count++;
        end
        if (i_last_pixel) begin
            n = (acc_count == 0) ? 1 : acc_count;
            m.rgb_mae  = 16'(acc_rgb_abs / (3 * n));
            m.rgb_rms  = 16'(floor_sqrt(acc_rgb_sq / (3 * n)));
            m.lum_mae  = 16'(acc_lum_abs / n);
            m.lum_rms  = 16'(floor_sqrt(acc_lum_sq / n));
            m.max_err  = 16'(acc_max_err);
            m.base_lum = 16'(acc_base_lum / n);
            m.cand_lum = 16'(acc_cand_lum / n);
            m.above    = 23'(acc_above);
            m.total    = 23'(acc_count);
            pending_metrics = {pending_metrics, m};
            clear_sums();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) accumulate_pixel();
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            fail_seen = 1'b1;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_metrics m;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_metrics.size() == 0) begin
                fail_seen = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("mismatch: result with none expected");
            end else begin
                m = pending_metrics.pop_front();
                check_field("rgb_mean_abs_error", m.rgb_mae, o_rgb_mean_abs_error);
                check_field("rgb_rms_error", m.rgb_rms, o_rgb_rms_error);
                check_field("lum_mean_abs_error", m.lum_mae, o_lum_mean_abs_error);
                check_field("lum_rms_error", m.lum_rms, o_lum_rms_error);
                check_field("max_channel_error", m.max_err, o_max_channel_error);
                check_field("mean_base_lum", m.base_lum, o_mean_base_lum);
                check_field("mean_cand_lum", m.cand_lum, o_mean_cand_lum);
                check_field("above_count", m.above, o_above_count);
                check_field("total_pixels", m.total, o_total_pixels);
            end
        end
    end

    function automatic int gap_len();
        int r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Output back-pressure: short stalls mostly, a few long ones
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(99) < 25) begin
            stall_left <= gap_len();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_pixel(logic [15:0] br, logic [15:0] bg, logic [15:0] bb,
                              logic [15:0] cr, logic [15:0] cg, logic [15:0] cb,
                              logic last);
        int g;
        i_in_valid <= 1'b1;
        i_base_red <= br; i_base_green <= bg; i_base_blue <= bb;
        i_cand_red <= cr; i_cand_green <= cg; i_cand_blue <= cb;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_metrics.size() != 0) @(posedge i_clk);
        // leave room for the back end to settle
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        threshold = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_chan(int mode);
        case (mode)
            0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(4096, 0));
        endcase
    endfunction

    task automatic send_random_image(int len);
        logic [15:0] b[3], c[3];
        int mode, sp;
        for (int k = 0; k < len; k++) begin
            mode = $urandom_range(2);
            for (int j = 0; j < 3; j++) begin
                b[j] = rand_chan(mode);
                // near-threshold differences are common
                if ($urandom_range(2) == 0) begin
                    sp = $urandom_range(80);
                    c[j] = ($urandom_range(1) && b[j] >= 16'(sp)) ? b[j] - 16'(sp) :
                           (b[j] <= 16'hFFFF - 16'(sp) ? b[j] + 16'(sp) : b[j]);
                end else begin
                    c[j] = rand_chan(mode);
                end
            end
            send_pixel(b[0], b[1], b[2], c[0], c[1], c[2], k == len - 1);
        end
    endtask

    task automatic test_directed();
        quiet = 1'b1;
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // difference equal to the reset threshold, then one above
        send_pixel(16'd1000, 16'd1000, 16'd1000, 16'd1041, 16'd1000, 16'd1000, 1'b0);
        send_pixel(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1042, 16'd1000, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA, 16'h5555, 16'hEDCB, 1'b0);
        send_pixel(16'h8000, 16'h7FFF, 16'h0001, 16'h8001, 16'h7FFE, 16'hFFFF, 1'b0);
        send_pixel(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 1'b1);
        quiet = 1'b0;
    endtask

    task automatic test_threshold_extremes();
        write_threshold(16'h0000);
        test_directed();
        send_random_image(10);
        write_threshold(16'hFFFF);
        test_directed();
        send_random_image(10);
    endtask

    task automatic test_random_images();
        int sent = 0;
        int len;
        while (sent < 1300) begin
            if (sent % 300 == 0 && sent != 0) write_threshold(16'($urandom_range(200)));
            len = ($urandom_range(19) == 0) ? $urandom_range(150, 60) : $urandom_range(25, 1);
            quiet = ($urandom_range(7) == 0);
            send_random_image(len);
            sent += len;
        end
        quiet = 1'b0;
        write_threshold(16'd41);
        send_random_image(5);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_base_red = '0; i_base_green = '0; i_base_blue = '0;
        i_cand_red = '0; i_cand_green = '0; i_cand_blue = '0;
        i_last_pixel = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        stall_left = 0;
        quiet = 1'b0;
        mismatches = 0;
        fail_seen = 1'b0;
        threshold = THRESH_RESET;
        clear_sums();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_threshold_extremes();
        test_random_images();

        drain();
        if (!fail_seen) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
